// ===== rtl/dq_pkg.sv =====
// Package for the double-ended queue: command and status codes, the
// decoded operation word and the sequencer state type. No dependencies.
`default_nettype none

package dq_pkg;

  localparam int DQ_DEPTH = 16;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_SHOW_FRONT = 3'd2,
    KIND_SHOW_BACK  = 3'd3,
    KIND_POP_FRONT  = 3'd4,
    KIND_POP_BACK   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/dq_if.sv =====
// Valid/ready channel interfaces for the double-ended queue: the command
// channel and the result channel. No dependencies.
`default_nettype none

interface dq_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] item;
  logic               last;
  logic [1:0]         status;

  modport source (output valid, output item, output last, output status, input ready);
  modport sink   (input valid, input item, input last, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/dq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dq_front.sv =====
// Front end of the double-ended queue: accepts command words, drops unknown
// kinds and buffers decoded operations in a two-entry queue.
// Depends on dq_pkg and dq_if.
`default_nettype none

module dq_front (
  input  logic          clk,
  input  logic          rst,
  dq_cmd_if.sink        cmd,
  output logic          op_valid,
  input  logic          op_ready,
  output dq_pkg::op_t   op
);

  import dq_pkg::*;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       known;
  logic       push_q;
  logic       pop_q;

  always_comb begin
    case (kind_t'(cmd.kind))
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_SHOW_FRONT,
      KIND_SHOW_BACK, KIND_POP_FRONT, KIND_POP_BACK: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign cmd.ready = (count != 2'd2);
  assign op_valid  = (count != 2'd0);
  assign op        = slots[rd_ptr];
  assign push_q    = cmd.valid && cmd.ready && known;
  assign pop_q     = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (push_q) begin
      slots[wr_ptr] <= '{kind: kind_t'(cmd.kind), value: cmd.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_q) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_q) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_q, pop_q})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dq_back.sv =====
// Back end of the double-ended queue: ring store, front index, occupancy,
// the push/pop/show sequencer and the result register.
// Depends on dq_pkg, dq_if and dq_ram.
`default_nettype none

module dq_back #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  dq_pkg::op_t   op,
  dq_rsp_if.source      rsp
);

  import dq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  bk_state_t state, state_next;

  logic [IW-1:0] front_index, front_next;
  logic [CW-1:0] occupancy, occ_next;
  logic [IW-1:0] rd_addr, rd_addr_next;
  logic [IW-1:0] remaining, remaining_next;
  logic          backward, backward_next;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_item;
  logic                     out_last;
  status_t                  out_status;

  logic                     load;
  logic signed [DATA_W-1:0] load_item;
  logic                     load_last;
  status_t                  load_status;

  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  logic re_en;
  logic [IW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic          full, empty, slot_free, is_push, needs_slot, op_fire, starts_read;
  logic [SW-1:0] tail_sum, last_sum;
  logic [IW-1:0] push_pos, last_pos, front_dec, front_inc, next_fwd, next_bwd;

  assign full       = (occupancy == CW'(DEPTH));
  assign empty      = (occupancy == '0);
  assign slot_free  = !out_valid || rsp.ready;
  assign is_push    = op.kind inside {KIND_PUSH_FRONT, KIND_PUSH_BACK};
  assign needs_slot = is_push || empty;
  assign op_ready   = (state == BK_IDLE) && (slot_free || !needs_slot);
  assign op_fire    = op_valid && op_ready;
  assign starts_read = op_fire && !is_push && !empty;

  assign tail_sum  = SW'(front_index) + SW'(occupancy);
  assign last_sum  = tail_sum - SW'(1);
  assign push_pos  = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
  assign last_pos  = (last_sum >= SW'(DEPTH)) ? IW'(last_sum - SW'(DEPTH)) : IW'(last_sum);
  assign front_dec = (front_index == '0) ? IW'(DEPTH - 1) : front_index - IW'(1);
  assign front_inc = (front_index == IW'(DEPTH - 1)) ? '0 : front_index + IW'(1);
  assign next_fwd  = (rd_addr == IW'(DEPTH - 1)) ? '0 : rd_addr + IW'(1);
  assign next_bwd  = (rd_addr == '0) ? IW'(DEPTH - 1) : rd_addr - IW'(1);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (starts_read) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free && (remaining == '0)) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = front_index;
    re_en          = 1'b0;
    ram_raddr      = rd_addr;
    front_next     = front_index;
    occ_next       = occupancy;
    rd_addr_next   = rd_addr;
    remaining_next = remaining;
    backward_next  = backward;
    load           = 1'b0;
    load_item      = '0;
    load_last      = 1'b1;
    load_status    = ST_OK;
    case (state)
      BK_IDLE: begin
        if (op_fire) begin
          case (op.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              load = 1'b1;
              if (full) begin
                load_status = ST_FULL;
              end else begin
                ram_we   = 1'b1;
                occ_next = occupancy + CW'(1);
                if (op.kind == KIND_PUSH_FRONT) begin
                  ram_waddr  = front_dec;
                  front_next = front_dec;
                end else begin
                  ram_waddr = push_pos;
                end
              end
            end
            KIND_SHOW_FRONT, KIND_SHOW_BACK, KIND_POP_FRONT, KIND_POP_BACK: begin
              if (empty) begin
                load        = 1'b1;
                load_status = ST_EMPTY;
              end else begin
                re_en = 1'b1;
                if (op.kind == KIND_SHOW_FRONT || op.kind == KIND_POP_FRONT) begin
                  ram_raddr = front_index;
                end else begin
                  ram_raddr = last_pos;
                end
                rd_addr_next  = ram_raddr;
                backward_next = (op.kind == KIND_SHOW_BACK);
                if (op.kind == KIND_SHOW_FRONT || op.kind == KIND_SHOW_BACK) begin
                  remaining_next = IW'(occupancy - CW'(1));
                end else begin
                  remaining_next = '0;
                  occ_next       = occupancy - CW'(1);
                  if (op.kind == KIND_POP_FRONT) begin
                    front_next = front_inc;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_item = ram_rdata;
          load_last = (remaining == '0);
          if (remaining != '0) begin
            re_en          = 1'b1;
            ram_raddr      = backward ? next_bwd : next_fwd;
            rd_addr_next   = ram_raddr;
            remaining_next = remaining - IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (op.value),
    .re    (re_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      front_index <= '0;
      occupancy   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_next;
      occupancy   <= occ_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr   <= rd_addr_next;
    remaining <= remaining_next;
    backward  <= backward_next;
    if (load) begin
      out_item   <= load_item;
      out_last   <= load_last;
      out_status <= load_status;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.item   = out_item;
  assign rsp.last   = out_last;
  assign rsp.status = out_status;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(DEPTH))
    else $error("Occupancy exceeds the store depth.");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front_index <= IW'(DEPTH - 1))
    else $error("Front index is outside the ring store.");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (op_fire && !full && (op.kind == KIND_PUSH_FRONT || op.kind == KIND_PUSH_BACK))
    |=> (occupancy == $past(occupancy) + CW'(1)))
    else $error("Accepted push did not grow the queue by one.");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (op_fire && !empty && (op.kind == KIND_POP_FRONT || op.kind == KIND_POP_BACK))
    |=> (occupancy == $past(occupancy) - CW'(1)) && (state == BK_EMIT))
    else $error("Accepted pop did not shrink the queue and start a read.");

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words.
// Top level: front end (dq_front) and back end (dq_back). Depends on dq_pkg and dq_if.
//
// The cmd channel carries one command word: kind and value. The rsp channel
// returns result words: item, last and status. Both use valid/ready; a word
// moves at a rising edge with valid and ready high. Kinds six and seven are
// accepted and produce no result.
// A push result passes through the command queue and then the result register;
// a pop or a show word also passes the registered read of the ring store.
// Commands enter a two-entry queue at one per cycle while it is not full. The
// back end executes a push from its idle state; a pop or a show starts a read
// and emits its words from the emit state, paced by the registered read of the
// ring store, one entry per cycle through its single read port unless stalled.
// Reset (rst, synchronous) empties the queue and the command buffer; the
// ring store is not cleared and needs no clearing pass.
// When the receiver holds rsp.ready low, the result register holds its word,
// the back end waits, and the command queue fills and then stalls cmd.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  dq_cmd_if.sink    cmd,
  dq_rsp_if.source  rsp
);

  import dq_pkg::*;

  logic op_valid;
  logic op_ready;
  op_t  op;

  dq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed table, then shaped random
// commands under varying backpressure, all scored against a behavioral deque.
// Depends on dq_pkg, the dq_cmd_if and dq_rsp_if interfaces, and the RTL top level.

module tb_top;
  import dq_pkg::*;

  localparam logic [2:0] KIND_RESERVED_LO = 3'd6;
  localparam logic [2:0] KIND_RESERVED_HI = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int WORDS_PER_PHASE = 96;

  typedef struct {
    logic signed [31:0] item;
    logic               last;
    status_t            status;
  } result_word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [4:0]         reps;
    logic               fresh;
    logic               typed;
    logic signed [31:0] want_item;
    status_t            want_status;
  } stim_row_t;

  localparam stim_row_t DIRECTED [16] = '{
    '{KIND_POP_FRONT,   32'sd0,           5'd1, 1'b0, 1'b1, 32'sd0,           ST_EMPTY},
    '{KIND_POP_BACK,    32'sd0,           5'd1, 1'b0, 1'b1, 32'sd0,           ST_EMPTY},
    '{KIND_SHOW_FRONT,  32'sd0,           5'd1, 1'b0, 1'b1, 32'sd0,           ST_EMPTY},
    '{KIND_SHOW_BACK,   32'sd0,           5'd1, 1'b0, 1'b1, 32'sd0,           ST_EMPTY},
    '{KIND_RESERVED_LO, 32'sd0,           5'd1, 1'b1, 1'b0, 32'sd0,           ST_OK},
    '{KIND_RESERVED_HI, 32'sd0,           5'd1, 1'b1, 1'b0, 32'sd0,           ST_OK},
    '{KIND_PUSH_BACK,   32'sh7FFFFFFF,    5'd1, 1'b0, 1'b1, 32'sd0,           ST_OK},
    '{KIND_POP_FRONT,   32'sd0,           5'd1, 1'b0, 1'b1, 32'sh7FFFFFFF,    ST_OK},
    '{KIND_PUSH_FRONT,  32'sh80000000,    5'd1, 1'b0, 1'b1, 32'sd0,           ST_OK},
    '{KIND_POP_BACK,    32'sd0,           5'd1, 1'b0, 1'b1, 32'sh80000000,    ST_OK},
    '{KIND_PUSH_FRONT,  32'sd0,           5'd8, 1'b1, 1'b0, 32'sd0,           ST_OK},
    '{KIND_PUSH_BACK,   32'sd0,           5'd8, 1'b1, 1'b0, 32'sd0,           ST_OK},
    '{KIND_PUSH_FRONT,  -32'sd1,          5'd1, 1'b0, 1'b1, 32'sd0,           ST_FULL},
    '{KIND_PUSH_BACK,   32'sh5A5A5A5A,    5'd1, 1'b0, 1'b1, 32'sd0,           ST_FULL},
    '{KIND_SHOW_FRONT,  32'sd0,           5'd1, 1'b0, 1'b0, 32'sd0,           ST_OK},
    '{KIND_SHOW_BACK,   32'sd0,           5'd1, 1'b0, 1'b0, 32'sd0,           ST_OK}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  dq_cmd_if cmd_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  logic signed [31:0] ring_store [DQ_DEPTH];
  logic [3:0]         head_pos = 4'd0;
  logic [4:0]         fill_level = 5'd0;
  result_word_t       awaited [$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 gap_pct = 0;
  int                 stall_pct = 0;

  function automatic void expect_word(input logic signed [31:0] item, input logic last,
                                      input status_t status);
    result_word_t w;
    w.item = item;
    w.last = last;
    w.status = status;
    awaited.push_back(w);
  endfunction

  function automatic void apply_command(input logic [2:0] k, input logic signed [31:0] v);
    logic [3:0] pos;
    logic [4:0] off;
    case (k)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (fill_level == 5'(DQ_DEPTH)) begin
          expect_word(32'sd0, 1'b1, ST_FULL);
        end else begin
          if (k == KIND_PUSH_FRONT) begin
            head_pos = head_pos - 4'd1;
            ring_store[head_pos] = v;
          end else begin
            pos = head_pos + fill_level[3:0];
            ring_store[pos] = v;
          end
          fill_level = fill_level + 5'd1;
          expect_word(32'sd0, 1'b1, ST_OK);
        end
      end
      KIND_SHOW_FRONT, KIND_SHOW_BACK: begin
        if (fill_level == 5'd0) begin
          expect_word(32'sd0, 1'b1, ST_EMPTY);
        end else begin
          for (int i = 0; i < fill_level; i++) begin
            off = (k == KIND_SHOW_FRONT) ? 5'(i) : fill_level - 5'd1 - 5'(i);
            pos = head_pos + off[3:0];
            expect_word(ring_store[pos], (i == fill_level - 1), ST_OK);
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (fill_level == 5'd0) begin
          expect_word(32'sd0, 1'b1, ST_EMPTY);
        end else begin
          if (k == KIND_POP_FRONT) begin
            pos = head_pos;
            head_pos = head_pos + 4'd1;
          end else begin
            pos = head_pos + fill_level[3:0] - 4'd1;
          end
          fill_level = fill_level - 5'd1;
          expect_word(ring_store[pos], 1'b1, ST_OK);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic drive_word(input logic [2:0] k, input logic signed [31:0] v);
    while ($urandom_range(99) < gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind <= k;
    cmd_ch.value <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    apply_command(k, v);
  endtask

  task automatic drain_results;
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    result_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: expected none, got item %0d last %0b status %0d",
                 $time, rsp_ch.item, rsp_ch.last, rsp_ch.status);
        mismatch_count++;
      end else begin
        want = awaited.pop_front();
        if (rsp_ch.item !== want.item || rsp_ch.last !== want.last ||
            rsp_ch.status !== want.status) begin
          $display("%0t: expected item %0d last %0b status %0d, got item %0d last %0b status %0d",
                   $time, want.item, want.last, want.status,
                   rsp_ch.item, rsp_ch.last, rsp_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t          row;
    int                 counted;
    int                 roll;
    bit                 filling;
    logic [2:0]         k;
    logic signed [31:0] v;

    cmd_ch.valid = 1'b0;
    cmd_ch.kind = KIND_PUSH_FRONT;
    cmd_ch.value = 32'sd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 15;
    stall_pct = 69;
    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      for (int n = 0; n < row.reps; n++) begin
        v = row.fresh ? $signed($urandom) : row.value;
        drive_word(row.kind, v);
        if (row.typed) begin
          void'(awaited.pop_back());
          expect_word(row.want_item, 1'b1, row.want_status);
        end
      end
    end
    drain_results();

    filling = 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 15 : (phase == 1) ? 69 : 0;
      stall_pct = (phase == 0) ? 69 : (phase == 1) ? 15 : 0;
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        if (fill_level == 5'(DQ_DEPTH) && $urandom_range(3) == 0) filling = 1'b0;
        if (fill_level == 5'd0 && $urandom_range(3) == 0) filling = 1'b1;
        roll = $urandom_range(99);
        if (roll < 4) begin
          k = $urandom_range(1) ? KIND_RESERVED_HI : KIND_RESERVED_LO;
        end else if (roll < 14) begin
          k = $urandom_range(1) ? KIND_SHOW_BACK : KIND_SHOW_FRONT;
        end else if (($urandom_range(99) < 75) == filling) begin
          k = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        end else begin
          k = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
        end
        case ($urandom_range(9))
          0: v = 32'sh7FFFFFFF;
          1: v = 32'sh80000000;
          2: v = 32'sd0;
          3: v = -32'sd1;
          default: v = $signed($urandom);
        endcase
        drive_word(k, v);
        if (k != KIND_RESERVED_LO && k != KIND_RESERVED_HI) counted++;
      end
      drain_results();
    end

    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_ram.sv
rtl/dq_front.sv
rtl/dq_back.sv
rtl/double_ended_queue.sv
bench/tb_top.sv
